FILE: rtl/vru_pkg.sv
package vru_pkg;

  // Fixed-point format of the inputs and results.
  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned IN_W      = 16;
  localparam int unsigned OUT_W     = 20;

  // Square root: radicand width, root width, iterations per stage, stage count.
  localparam int unsigned RAD_W     = 42;
  localparam int unsigned ROOT_W    = RAD_W / 2;
  localparam int unsigned REM_W     = ROOT_W + 2;
  localparam int unsigned SQ_PER    = 3;
  localparam int unsigned SQ_STAGES = ROOT_W / SQ_PER;

  // Widths of the intermediate terms.
  localparam int unsigned D_W   = 19;  // d = -(I.N)
  localparam int unsigned E2_W  = 19;  // eta squared
  localparam int unsigned T_W   = 24;  // 1 - d^2
  localparam int unsigned ET_W  = 44;  // e2 * t
  localparam int unsigned K_W   = 31;  // k
  localparam int unsigned ED_W  = 22;  // eta * d
  localparam int unsigned C_W   = 23;  // eta * d - sqrt(k)

  // Partial state of the digit-by-digit square root.
  typedef struct packed {
    logic [RAD_W-1:0]  rad;   // radicand bits still to be consumed, MSB first
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // Payload carried alongside the square root stages.
  typedef struct packed {
    logic signed [IN_W-1:0] ix;
    logic signed [IN_W-1:0] iy;
    logic signed [IN_W-1:0] iz;
    logic signed [IN_W-1:0] nx;
    logic signed [IN_W-1:0] ny;
    logic signed [IN_W-1:0] nz;
    logic [IN_W-1:0]        eta;
    logic signed [ED_W-1:0] ed;
    logic                   tir;
  } carry_t;

endpackage

FILE: rtl/vru_sqrt_stage.sv
module vru_sqrt_stage
  import vru_pkg::*;
(
  input  sqrt_t sq_i,
  output sqrt_t sq_o
);

  // Three restoring square root iterations, two radicand bits each.
  always_comb begin
    logic [REM_W+1:0]  rem_w;
    logic [REM_W+1:0]  trial;
    sqrt_t             s;
    s = sq_i;
    for (int n = 0; n < SQ_PER; n++) begin
      rem_w = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      s.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rem_w >= trial) begin
        rem_w  = rem_w - trial;
        s.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
        s.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      s.rem = rem_w[REM_W-1:0];
    end
    sq_o = s;
  end

endmodule

FILE: rtl/vector_refraction_unit.sv
// Channel   Dir  Width  Contents
// s_axis    in   112    incident x/y/z, normal x/y/z, index ratio
// m_axis    out  64+2   refracted x/y/z in tdata; total reflection, saturated in tuser
//
// One item is taken per cycle unless a full pipeline is stalled by m_axis_tready.
// The square root takes 7 stages of 3 iterations each, the rest is multiply/round stages.
// Reset clears all stage valid bits; payload registers are not reset.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles are squeezed out and input is taken whenever the output register is free.
module vector_refraction_unit
  import vru_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // incident_x[15:0], incident_y[31:16], incident_z[47:32], normal_x[63:48],
  // normal_y[79:64], normal_z[95:80], index_ratio[111:96]
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // refracted_x[19:0], refracted_y[39:20], refracted_z[59:40], zero pad[63:60]
  output logic [63:0]  m_axis_tdata,
  // total_reflection[0], saturated[1]
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned NS     = 9 + SQ_STAGES;
  localparam int unsigned S_SQ0  = 6;
  localparam int unsigned S_C    = S_SQ0 + SQ_STAGES;
  localparam int unsigned S_MUL  = S_C + 1;
  localparam int unsigned S_OUT  = S_MUL + 1;
  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  // Stage enables: a stage loads when it is empty or the next one moves.
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || m_axis_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld_q[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_q[i] <= vld_q[i-1];
        end
      end
    end
  end

  // Input unpack.
  logic signed [IN_W-1:0] in_ix, in_iy, in_iz, in_nx, in_ny, in_nz;
  logic [IN_W-1:0]        in_eta;
  assign in_ix  = s_axis_tdata[15:0];
  assign in_iy  = s_axis_tdata[31:16];
  assign in_iz  = s_axis_tdata[47:32];
  assign in_nx  = s_axis_tdata[63:48];
  assign in_ny  = s_axis_tdata[79:64];
  assign in_nz  = s_axis_tdata[95:80];
  assign in_eta = s_axis_tdata[111:96];

  // Stage 0: dot product terms and eta squared.
  logic signed [31:0] pxx_q, pyy_q, pzz_q;
  logic [31:0]        ee_q;
  carry_t             c0_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pxx_q <= in_ix * in_nx;
      pyy_q <= in_iy * in_ny;
      pzz_q <= in_iz * in_nz;
      ee_q  <= in_eta * in_eta;
      c0_q  <= '{ix: in_ix, iy: in_iy, iz: in_iz, nx: in_nx, ny: in_ny, nz: in_nz,
                 eta: in_eta, ed: '0, tir: 1'b0};
    end
  end

  // Stage 1: d and e2, rounded to FRAC_BITS.
  logic signed [63:0]     dsum;
  logic signed [D_W-1:0]  d1_q;
  logic [E2_W-1:0]        e2_1_q;
  carry_t                 c1_q;
  assign dsum = HALF - (64'(pxx_q) + 64'(pyy_q) + 64'(pzz_q));
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      d1_q   <= D_W'(dsum >>> FRAC_BITS);
      e2_1_q <= E2_W'((33'(ee_q) + 33'(HALF[31:0])) >> FRAC_BITS);
      c1_q   <= c0_q;
    end
  end

  // Stage 2: d squared and eta times d.
  logic signed [37:0]     dd2_q;
  logic signed [35:0]     edp2_q;
  logic [E2_W-1:0]        e2_2_q;
  carry_t                 c2_q;
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      dd2_q  <= 38'(d1_q * d1_q);
      edp2_q <= $signed({1'b0, c1_q.eta}) * d1_q;
      e2_2_q <= e2_1_q;
      c2_q   <= c1_q;
    end
  end

  // Stage 3: t = 1 - d^2 and eta*d, rounded.
  logic signed [63:0]     tw;
  logic signed [63:0]     edw;
  logic signed [T_W-1:0]  t3_q;
  logic [E2_W-1:0]        e2_3_q;
  carry_t                 c3_d;
  carry_t                 c3_q;
  assign tw  = (64'sd1 <<< (2 * FRAC_BITS)) - 64'(dd2_q) + HALF;
  assign edw = 64'(edp2_q) + HALF;
  always_comb begin
    c3_d    = c2_q;
    c3_d.ed = ED_W'(edw >>> FRAC_BITS);
  end
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      t3_q   <= T_W'(tw >>> FRAC_BITS);
      e2_3_q <= e2_2_q;
      c3_q   <= c3_d;
    end
  end

  // Stage 4: e2 times t.
  logic signed [ET_W-1:0] et4_q;
  carry_t                 c4_q;
  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      et4_q <= ET_W'($signed({1'b0, e2_3_q}) * t3_q);
      c4_q  <= c3_q;
    end
  end

  // Stage 5: k, total reflection test, square root set-up.
  logic signed [63:0]    kw;
  logic signed [K_W-1:0] k5;
  sqrt_t                 sq5_q;
  carry_t                c5_d;
  carry_t                c5_q;
  assign kw = (64'sd1 <<< FRAC_BITS) - ((64'(et4_q) + HALF) >>> FRAC_BITS);
  assign k5 = K_W'(kw);
  always_comb begin
    c5_d     = c4_q;
    c5_d.tir = k5[K_W-1] || (k5 == '0);
  end
  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      sq5_q <= '{rad: {k5[RAD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}}, rem: '0, root: '0};
      c5_q  <= c5_d;
    end
  end

  // Square root stages.
  sqrt_t  sq_q [SQ_STAGES];
  carry_t cs_q [SQ_STAGES];
  for (genvar g = 0; g < SQ_STAGES; g++) begin : g_sqrt
    sqrt_t sq_in, sq_out;
    assign sq_in = (g == 0) ? sq5_q : sq_q[(g == 0) ? 0 : g-1];
    vru_sqrt_stage u_step (
      .sq_i (sq_in),
      .sq_o (sq_out)
    );
    always_ff @(posedge clk_i) begin
      if (en[S_SQ0+g]) begin
        sq_q[g] <= sq_out;
        cs_q[g] <= (g == 0) ? c5_q : cs_q[(g == 0) ? 0 : g-1];
      end
    end
  end

  // Coefficient c = eta*d - sqrt(k).
  logic signed [C_W-1:0] c_q;
  carry_t                cc_q;
  always_ff @(posedge clk_i) begin
    if (en[S_C]) begin
      c_q  <= C_W'(cs_q[SQ_STAGES-1].ed) - $signed({2'b00, sq_q[SQ_STAGES-1].root});
      cc_q <= cs_q[SQ_STAGES-1];
    end
  end

  // Per-component products eta*I and c*N.
  logic signed [32:0] pix_q, piy_q, piz_q;
  logic signed [38:0] pcx_q, pcy_q, pcz_q;
  logic               tir_m_q;
  always_ff @(posedge clk_i) begin
    if (en[S_MUL]) begin
      pix_q   <= $signed({1'b0, cc_q.eta}) * cc_q.ix;
      piy_q   <= $signed({1'b0, cc_q.eta}) * cc_q.iy;
      piz_q   <= $signed({1'b0, cc_q.eta}) * cc_q.iz;
      pcx_q   <= c_q * cc_q.nx;
      pcy_q   <= c_q * cc_q.ny;
      pcz_q   <= c_q * cc_q.nz;
      tir_m_q <= cc_q.tir;
    end
  end

  // Final sum, rounding and clamp.
  logic signed [63:0]     rx, ry, rz;
  logic [OUT_W-1:0]       ox, oy, oz;
  logic                   sx, sy, sz;
  localparam logic signed [63:0] OMAX = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
  localparam logic signed [63:0] OMIN = -(64'sd1 <<< (OUT_W - 1));

  assign rx = (64'(pix_q) + 64'(pcx_q) + HALF) >>> FRAC_BITS;
  assign ry = (64'(piy_q) + 64'(pcy_q) + HALF) >>> FRAC_BITS;
  assign rz = (64'(piz_q) + 64'(pcz_q) + HALF) >>> FRAC_BITS;

  always_comb begin
    sx = (rx > OMAX) || (rx < OMIN);
    sy = (ry > OMAX) || (ry < OMIN);
    sz = (rz > OMAX) || (rz < OMIN);
    ox = (rx > OMAX) ? OMAX[OUT_W-1:0] : (rx < OMIN) ? OMIN[OUT_W-1:0] : rx[OUT_W-1:0];
    oy = (ry > OMAX) ? OMAX[OUT_W-1:0] : (ry < OMIN) ? OMIN[OUT_W-1:0] : ry[OUT_W-1:0];
    oz = (rz > OMAX) ? OMAX[OUT_W-1:0] : (rz < OMIN) ? OMIN[OUT_W-1:0] : rz[OUT_W-1:0];
  end

  logic [3*OUT_W-1:0] out_data_q;
  logic               out_tir_q, out_sat_q;
  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      out_data_q <= tir_m_q ? '0 : {oz, oy, ox};
      out_tir_q  <= tir_m_q;
      out_sat_q  <= !tir_m_q && (sx || sy || sz);
    end
  end

  assign m_axis_tvalid = vld_q[S_OUT];
  assign m_axis_tdata  = {4'b0000, out_data_q};
  assign m_axis_tuser  = {out_sat_q, out_tir_q};

  // A total reflection result is the zero vector with no saturation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && out_tir_q) |-> (out_data_q == '0 && !out_sat_q))
    else $error("total reflection result not zero");

  // An empty output register opens the whole pipeline to input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[S_OUT] |-> s_axis_tready)
    else $error("input stalled with empty output");

  // An accepted item always lands in the first stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> vld_q[0])
    else $error("accepted item lost at entry");

endmodule
